// ----- hw/rtl/szdd_pkg.sv -----
// SZDD detect/decode package: shared types, codes and constants.
// No dependencies; imported by every module of the block.
package szdd_pkg;

   localparam int DEF_RING_SIZE      = 4096;
   localparam int DEF_POSITION_WIDTH = 32;
   localparam int CNT_W              = 26;
   localparam int SIZE_W             = 25;
   localparam int LEN_W              = 5;

   localparam logic [31:0] MAGIC_STD_LO   = 32'h88F0_2733;
   localparam logic [31:0] MAGIC_STD_HI   = 32'h535A_4444;
   localparam logic [31:0] MAGIC_SHORT_HI = 32'h535A_2088;
   localparam logic [31:0] MAGIC_SHORT_LO = 32'hF027_33D1;
   localparam logic [15:0] MODE_CODE      = 16'h4100;
   localparam logic [15:0] MODE_MASK      = 16'hFF00;
   localparam logic [31:0] SIZE_MIN       = 32'd128;
   localparam logic [31:0] SIZE_MAX       = 32'h01FF_FFFF;
   localparam logic [7:0]  SPACE_BYTE     = 8'h20;
   localparam logic [7:0]  NAME_LOW       = 8'h61;
   localparam logic [7:0]  NAME_HIGH      = 8'h7A;
   localparam int          START_BACK_STD   = 16;
   localparam int          START_BACK_SHORT = 18;
   localparam int          STD_CHECK_OFF    = 6;
   localparam int          SHORT_CHECK_OFF  = 4;
   localparam int          MATCH_MIN        = 3;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_HEADER = 2'd1,
      PH_DECODE = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [0:0] {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_LITERAL,
      ACT_MATCH
   } act_type;

   typedef enum logic [1:0] {
      SEL_LITERAL,
      SEL_COPY,
      SEL_STATUS
   } out_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT_LIT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FINISH,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic        load;
      logic        eval;
      logic        copy_rd;
      logic        finish;
      logic        out_load;
      out_sel_type out_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      act_type act;
      logic    copy_last;
      logic    out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/szdd_ctrl.sv -----
// SZDD controller: sequences accept, evaluate, copy, finish and status steps.
// Depends on szdd_pkg.
module szdd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  szdd_pkg::dp_status_type status,
   output szdd_pkg::ctrl_cmd_type  cmd
);
   import szdd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.out_sel  = SEL_STATUS;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            unique case (status.act)
               ACT_LITERAL: state_in = ST_EMIT_LIT;
               ACT_MATCH:   state_in = ST_COPY_RD;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_EMIT_LIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_LITERAL;
               state_in     = ST_FINISH;
            end
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_COPY;
               state_in     = status.copy_last ? ST_FINISH : ST_COPY_RD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_STATUS;
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_STATUS;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/szdd_dpath.sv -----
// SZDD datapath: header detection, LZSS token state, ring memory, counters
// and the result register. Depends on szdd_pkg; driven by szdd_ctrl.
module szdd_dpath #(
   parameter int RING_SIZE      = szdd_pkg::DEF_RING_SIZE,
   parameter int POSITION_WIDTH = szdd_pkg::DEF_POSITION_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_data_byte,
   input  szdd_pkg::ctrl_cmd_type  cmd,
   output szdd_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_result_kind,
   output logic [7:0]              rsp_decoded_byte,
   output logic [1:0]              rsp_phase,
   output logic [31:0]             rsp_stream_start,
   output logic [szdd_pkg::CNT_W-1:0] rsp_compressed_length,
   output logic [szdd_pkg::CNT_W-1:0] rsp_decoded_length,
   output logic                    rsp_variant,
   output logic                    rsp_last
);
   import szdd_pkg::*;

   localparam int AW = $clog2(RING_SIZE);
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
   localparam logic [CNT_W-1:0]          CNT_MAX = '1;
   localparam logic [AW:0]               FILL_FULL = (AW+1)'(RING_SIZE);
   localparam logic [AW-1:0] WSTART_STD   = AW'(RING_SIZE - START_BACK_STD);
   localparam logic [AW-1:0] WSTART_SHORT = AW'(RING_SIZE - START_BACK_SHORT);

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // stream and header state
   logic [63:0]               history_ff, history_in;
   phase_type                 phase_ff, phase_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [POSITION_WIDTH-1:0] header_mark_ff, header_mark_in;
   logic [SIZE_W-1:0]         stated_ff, stated_in;
   logic                      variant_ff, variant_in;
   logic [7:0]                byte_ff, byte_in;
   // token state
   logic [8:0]                flag_ff, flag_in;
   logic                      token_step_ff, token_step_in;
   logic                      token_done_ff, token_done_in;
   logic [7:0]                match_low_ff, match_low_in;
   logic [CNT_W-1:0]          dcount_ff, dcount_in;
   logic [CNT_W-1:0]          ccount_ff, ccount_in;
   // ring addressing; fill count marks entries written since the header
   logic [AW-1:0]             wp_ff, wp_in;
   logic [AW-1:0]             start_ff, start_in;
   logic [AW:0]               fill_ff, fill_in;
   logic [AW-1:0]             src_ff, src_in;
   logic [LEN_W-1:0]          remain_ff, remain_in;
   logic                      hit_ff, hit_in;
   logic [7:0]                rdata_ff;
   logic [7:0]                ring_mem [RING_SIZE];
   logic                      ring_we;
   logic [7:0]                ring_wdata;
   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   kind_type                  rsp_kind_ff, rsp_kind_in;
   logic [7:0]                rsp_byte_ff, rsp_byte_in;
   phase_type                 rsp_phase_ff, rsp_phase_in;
   logic [31:0]               rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0]          rsp_clen_ff, rsp_clen_in;
   logic [CNT_W-1:0]          rsp_dlen_ff, rsp_dlen_in;
   logic                      rsp_var_ff, rsp_var_in;

   logic [31:0]               hi, lo, size32;
   logic [7:0]                name_byte;
   logic [POSITION_WIDTH-1:0] off;
   logic                      std_ok, short_ok, magic_hit;
   logic [7:0]                copy_byte;

   assign hi        = history_ff[63:32];
   assign lo        = history_ff[31:0];
   assign name_byte = hi[7:0];
   assign off       = position_ff - header_mark_ff;
   assign size32    = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
   assign magic_hit = (lo == MAGIC_STD_LO && hi == MAGIC_STD_HI) ||
                      (hi == MAGIC_SHORT_HI && lo == MAGIC_SHORT_LO);
   assign std_ok    = off == POSITION_WIDTH'(STD_CHECK_OFF) &&
                      (hi[15:0] & MODE_MASK) == MODE_CODE &&
                      (name_byte == 8'd0 || name_byte > NAME_LOW) &&
                      name_byte < NAME_HIGH;
   assign short_ok  = off == POSITION_WIDTH'(SHORT_CHECK_OFF) && hi != MAGIC_STD_LO;
   assign copy_byte = hit_ff ? rdata_ff : SPACE_BYTE;

   always_comb begin
      status.act = ACT_NONE;
      if (phase_ff == PH_DECODE) begin
         if (token_step_ff) begin
            status.act = ACT_MATCH;
         end else if (flag_ff > 9'd1 && flag_ff[0]) begin
            status.act = ACT_LITERAL;
         end
      end
      status.copy_last = remain_ff == LEN_W'(1);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      history_in     = history_ff;
      phase_in       = phase_ff;
      position_in    = position_ff;
      header_mark_in = header_mark_ff;
      stated_in      = stated_ff;
      variant_in     = variant_ff;
      byte_in        = byte_ff;
      flag_in        = flag_ff;
      token_step_in  = token_step_ff;
      token_done_in  = token_done_ff;
      match_low_in   = match_low_ff;
      dcount_in      = dcount_ff;
      ccount_in      = ccount_ff;
      wp_in          = wp_ff;
      start_in       = start_ff;
      fill_in        = fill_ff;
      src_in         = src_ff;
      remain_in      = remain_ff;
      hit_in         = hit_ff;
      ring_we        = 1'b0;
      ring_wdata     = byte_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_clen_in    = rsp_clen_ff;
      rsp_dlen_in    = rsp_dlen_ff;
      rsp_var_in     = rsp_var_ff;

      if (cmd.load) begin
         history_in = {history_ff[55:0], req_data_byte};
         byte_in    = req_data_byte;
      end

      if (cmd.eval) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (magic_hit) begin
                  phase_in       = PH_HEADER;
                  header_mark_in = position_ff;
               end
            end
            PH_HEADER: begin
               if (lo != 32'd0 && (std_ok || short_ok)) begin
                  if (size32 > SIZE_MAX || size32 < SIZE_MIN) begin
                     phase_in = PH_SEARCH;
                  end else begin
                     variant_in     = short_ok;
                     stated_in      = size32[SIZE_W-1:0];
                     wp_in          = short_ok ? WSTART_SHORT : WSTART_STD;
                     start_in       = short_ok ? WSTART_SHORT : WSTART_STD;
                     fill_in        = '0;
                     flag_in        = '0;
                     token_step_in  = 1'b0;
                     match_low_in   = '0;
                     dcount_in      = '0;
                     ccount_in      = '0;
                     header_mark_in = (position_ff != POS_MAX) ? position_ff + 1'b1
                                                               : POS_MAX;
                     phase_in       = PH_DECODE;
                  end
               end else if (off >= POSITION_WIDTH'(STD_CHECK_OFF) || position_ff == POS_MAX) begin
                  phase_in = PH_SEARCH;
               end
            end
            PH_DECODE: begin
               ccount_in = sat_inc(ccount_ff);
               if (token_step_ff) begin
                  src_in        = AW'({byte_ff[7:4], match_low_ff});
                  remain_in     = LEN_W'(byte_ff[3:0]) + LEN_W'(MATCH_MIN);
                  token_step_in = 1'b0;
                  token_done_in = 1'b1;
               end else if (flag_ff < 9'd2) begin
                  flag_in = {1'b1, byte_ff};
               end else if (flag_ff[0]) begin
                  ring_we       = 1'b1;
                  ring_wdata    = byte_ff;
                  wp_in         = wp_ff + 1'b1;
                  dcount_in     = sat_inc(dcount_ff);
                  fill_in       = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
                  token_done_in = 1'b1;
               end else begin
                  match_low_in  = byte_ff;
                  token_step_in = 1'b1;
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end

      // entry is valid if written since the header, else it still holds a space
      if (cmd.copy_rd) begin
         hit_in = {1'b0, AW'(src_ff - start_ff)} < fill_ff;
      end

      if (cmd.out_load && cmd.out_sel == SEL_COPY) begin
         ring_we    = 1'b1;
         ring_wdata = copy_byte;
         wp_in      = wp_ff + 1'b1;
         src_in     = src_ff + 1'b1;
         remain_in  = remain_ff - 1'b1;
         dcount_in  = sat_inc(dcount_ff);
         fill_in    = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
      end

      if (cmd.finish) begin
         if (token_done_ff) begin
            token_done_in = 1'b0;
            flag_in       = flag_ff >> 1;
            if (dcount_ff >= CNT_W'(stated_ff)) begin
               phase_in = PH_DONE;
            end
         end
         if (position_ff != POS_MAX) begin
            position_in = position_ff + 1'b1;
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_BYTE;
         rsp_phase_in = PH_DECODE;
         rsp_start_in = '0;
         rsp_clen_in  = '0;
         rsp_dlen_in  = '0;
         rsp_var_in   = 1'b0;
         unique case (cmd.out_sel)
            SEL_LITERAL: rsp_byte_in = byte_ff;
            SEL_COPY:    rsp_byte_in = copy_byte;
            SEL_STATUS: begin
               rsp_kind_in  = KIND_STATUS;
               rsp_byte_in  = '0;
               rsp_phase_in = phase_ff;
               if (phase_ff == PH_DONE) begin
                  rsp_start_in = 32'(header_mark_ff);
                  rsp_clen_in  = ccount_ff;
                  rsp_dlen_in  = dcount_ff;
                  rsp_var_in   = variant_ff;
               end
            end
            default: rsp_byte_in = '0;
         endcase
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff     <= '0;
         phase_ff       <= PH_SEARCH;
         position_ff    <= '0;
         header_mark_ff <= '0;
         stated_ff      <= '0;
         variant_ff     <= 1'b0;
         flag_ff        <= '0;
         token_step_ff  <= 1'b0;
         token_done_ff  <= 1'b0;
         match_low_ff   <= '0;
         dcount_ff      <= '0;
         ccount_ff      <= '0;
         wp_ff          <= '0;
         start_ff       <= '0;
         fill_ff        <= '0;
         remain_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         history_ff     <= history_in;
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         header_mark_ff <= header_mark_in;
         stated_ff      <= stated_in;
         variant_ff     <= variant_in;
         flag_ff        <= flag_in;
         token_step_ff  <= token_step_in;
         token_done_ff  <= token_done_in;
         match_low_ff   <= match_low_in;
         dcount_ff      <= dcount_in;
         ccount_ff      <= ccount_in;
         wp_ff          <= wp_in;
         start_ff       <= start_in;
         fill_ff        <= fill_in;
         remain_ff      <= remain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      src_ff       <= src_in;
      hit_ff       <= hit_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_start_ff <= rsp_start_in;
      rsp_clen_ff  <= rsp_clen_in;
      rsp_dlen_ff  <= rsp_dlen_in;
      rsp_var_ff   <= rsp_var_in;
   end

   // ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= ring_wdata;
      end
      if (cmd.copy_rd) begin
         rdata_ff <= ring_mem[src_ff];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_decoded_byte      = rsp_byte_ff;
   assign rsp_phase             = rsp_phase_ff;
   assign rsp_stream_start      = rsp_start_ff;
   assign rsp_compressed_length = rsp_clen_ff;
   assign rsp_decoded_length    = rsp_dlen_ff;
   assign rsp_variant           = rsp_var_ff;
   assign rsp_last              = rsp_kind_ff == KIND_STATUS;

endmodule

// ----- hw/rtl/szdd_stream_detect_decode_top.sv -----
// SZDD stream detector and LZSS decoder, top level.
// Depends on szdd_pkg, szdd_ctrl and szdd_dpath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data_byte
//   rsp      out        rsp_valid/rsp_stall   kind, byte, phase, start, lengths,
//                                             variant, last
//
// One input byte is taken at a time. Search, header and flag bytes pass
// through accept, evaluate, finish and status; a literal adds an emit step;
// the second byte of a match adds, for each copied byte, one registered
// ring read and then one ring write through the single-port pair.
// Reset is synchronous; no clearing pass runs: a fill count since the header
// marks which ring entries were written, all others read as spaces.
// rsp_stall holds the result register and the controller waits on it; the
// next byte is taken once the status transfer is loaded.
module szdd_stream_detect_decode_top #(
   parameter int RING_SIZE      = szdd_pkg::DEF_RING_SIZE,
   parameter int POSITION_WIDTH = szdd_pkg::DEF_POSITION_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_result_kind,
   output logic [7:0]                 rsp_decoded_byte,
   output logic [1:0]                 rsp_phase,
   output logic [31:0]                rsp_stream_start,
   output logic [szdd_pkg::CNT_W-1:0] rsp_compressed_length,
   output logic [szdd_pkg::CNT_W-1:0] rsp_decoded_length,
   output logic                       rsp_variant,
   output logic                       rsp_last
);
   import szdd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller: sequencing only
   szdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: header check, token decode, ring, result register
   szdd_dpath #(
      .RING_SIZE      (RING_SIZE),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_data_byte         (req_data_byte),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_decoded_byte      (rsp_decoded_byte),
      .rsp_phase             (rsp_phase),
      .rsp_stream_start      (rsp_stream_start),
      .rsp_compressed_length (rsp_compressed_length),
      .rsp_decoded_length    (rsp_decoded_length),
      .rsp_variant           (rsp_variant),
      .rsp_last              (rsp_last)
   );

endmodule
